/* hw/rtl/smss_pkg.sv */
// Shared types and codes for the sparse matrix store.
package smss_pkg;

  localparam logic [2:0] OP_SET   = 3'd0;
  localparam logic [2:0] OP_GET   = 3'd1;
  localparam logic [2:0] OP_ALLOC = 3'd2;
  localparam logic [2:0] OP_LOAD  = 3'd3;
  localparam logic [2:0] OP_MAC   = 3'd4;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  localparam logic [0:0] CFG_ROWS = 1'd0;
  localparam logic [0:0] CFG_COLS = 1'd1;

  typedef struct packed {
    logic [2:0]         operation;
    logic [5:0]         row_index;
    logic [5:0]         col_index;
    logic signed [31:0] data_value;
    logic signed [31:0] addend;
  } req_t;

  typedef struct packed {
    logic signed [31:0] result_value;
    logic               found;
    logic [1:0]         status;
  } rsp_t;

  // controller -> datapath
  typedef struct packed {
    logic load_req;    // capture request
    logic clr_acc;     // acc <= addend
    logic rd_prev;     // read entry ptr-1 (shift source)
    logic ptr_clr;     // ptr <= 0
    logic ptr_inc;
    logic ptr_to_fill; // ptr <= fill (shift start)
    logic ptr_dec;
    logic wr_shift;    // write entry[ptr] <= rdata (from ptr-1)
    logic wr_new;      // write entry[ptr] new entry
    logic wr_over;     // overwrite value at ptr
    logic fill_inc;
    logic vec_wr;
    logic mac_mul;     // register product
    logic mac_add;     // acc += product
    logic out_load;    // build response
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic       in_range;
    logic [2:0] op;
    logic       at_end;   // ptr == fill
    logic       col_ge;   // read column >= request column
    logic       col_eq;
    logic       full;
    logic       ptr_gt_pos; // ptr > pos during shift
  } sts_t;

endpackage

/* hw/rtl/smss_ram.sv */
// Generic single-port-write RAM with registered read.
module smss_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

/* hw/rtl/smss_datapath.sv */
// Datapath: entry storage, fill counts, dense vector, pointer and accumulator.
module smss_datapath #(
  parameter int ROWS         = 64,
  parameter int COLS         = 64,
  parameter int ROW_CAPACITY = 16,
  parameter int DATA_WIDTH   = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  smss_pkg::req_t       req,
  input  logic [6:0]           active_rows,
  input  logic [6:0]           active_cols,
  input  smss_pkg::cmd_t       cmd,
  output smss_pkg::sts_t       sts,
  output smss_pkg::rsp_t       rsp
);
  localparam int RW = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int CW = (COLS > 1) ? $clog2(COLS) : 1;
  localparam int FW = $clog2(ROW_CAPACITY + 1);
  localparam int DEPTH = ROWS * ROW_CAPACITY;
  localparam int AW = $clog2(DEPTH) > 0 ? $clog2(DEPTH) : 1;
  localparam int EW = CW + DATA_WIDTH;
  // wide enough for the 7-bit bound registers and for ROWS / COLS themselves
  localparam int XW = (RW + 1 > 7) ? RW + 1 : 7;
  localparam int YW = (CW + 1 > 7) ? CW + 1 : 7;

  smss_pkg::req_t r;
  logic [RW-1:0] row;
  logic [CW-1:0] col;
  logic          in_range;

  // fill counts and vector live in RAMs; these bits mark written entries
  logic [ROWS-1:0] fill_vld;
  logic [COLS-1:0] vec_vld;
  logic            vec_vld_q;
  logic [RW-1:0]   fill_ra;
  logic [FW-1:0]   fill_q;
  logic [DATA_WIDTH-1:0] vec_q;
  logic [FW-1:0] fill_cur;
  logic [FW-1:0] ptr;
  logic [FW-1:0] pos;   // insert position
  logic [DATA_WIDTH-1:0] acc, prod, vsel;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [EW-1:0] wdata, rdata;
  logic [CW-1:0] rd_col;
  logic [DATA_WIDTH-1:0] rd_val;
  smss_pkg::rsp_t rsp_next;

  assign rd_col = rdata[EW-1 -: CW];
  assign rd_val = rdata[DATA_WIDTH-1:0];

  // entry address = row * capacity + ptr
  function automatic logic [AW-1:0] eaddr(input logic [RW-1:0] rw, input logic [FW-1:0] p);
    logic [AW+FW-1:0] t;
    t = (AW+FW)'(rw) * (AW+FW)'(ROW_CAPACITY) + (AW+FW)'(p);
    return t[AW-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      r <= req;
      row <= RW'(req.row_index);
      col <= CW'(req.col_index);
      in_range <= (req.operation == smss_pkg::OP_LOAD || (XW'(req.row_index) < XW'(active_rows)
                   && XW'(req.row_index) < XW'(ROWS)))
               && (req.operation == smss_pkg::OP_MAC || (YW'(req.col_index) < YW'(active_cols)
                   && YW'(req.col_index) < YW'(COLS)));
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ptr_clr) ptr <= '0;
    else if (cmd.ptr_inc) ptr <= ptr + 1'b1;
    else if (cmd.ptr_to_fill) begin
      ptr <= fill_cur;
      pos <= ptr;
    end else if (cmd.ptr_dec) ptr <= ptr - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_vld <= '0;
      vec_vld <= '0;
    end else begin
      if (cmd.fill_inc) fill_vld[row] <= 1'b1;
      if (cmd.vec_wr) vec_vld[col] <= 1'b1;
    end
  end

  // fill count of the addressed row, valid from the cycle after capture
  assign fill_ra = cmd.load_req ? RW'(req.row_index) : row;
  assign fill_cur = fill_vld[row] ? fill_q : '0;

  smss_ram #(.WIDTH(FW), .DEPTH(ROWS)) u_fill (
    .clk(clk), .we(cmd.fill_inc), .waddr(row), .wdata(fill_cur + 1'b1), .raddr(fill_ra),
    .rdata(fill_q)
  );

  // vector element of the column just read, available in the following cycle
  smss_ram #(.WIDTH(DATA_WIDTH), .DEPTH(COLS)) u_vec (
    .clk(clk), .we(cmd.vec_wr), .waddr(col), .wdata(DATA_WIDTH'($unsigned(r.data_value))),
    .raddr(rd_col), .rdata(vec_q)
  );

  always_ff @(posedge clk) begin
    vec_vld_q <= vec_vld[rd_col];
  end

  assign vsel = vec_vld_q ? vec_q : '0;

  // RAM read: shift reads entry ptr-1, scans read ptr
  always_comb begin
    raddr = eaddr(row, ptr);
    if (cmd.rd_prev) raddr = eaddr(row, ptr - 1'b1);
  end

  always_comb begin
    we = cmd.wr_shift | cmd.wr_new | cmd.wr_over;
    waddr = eaddr(row, ptr);
    if (cmd.wr_shift) wdata = rdata;
    else if (cmd.wr_new)
      wdata = {col, (r.operation == smss_pkg::OP_SET) ? DATA_WIDTH'($unsigned(r.data_value))
                                                      : DATA_WIDTH'(0)};
    else wdata = {col, DATA_WIDTH'($unsigned(r.data_value))};
  end

  smss_ram #(.WIDTH(EW), .DEPTH(DEPTH)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.clr_acc) acc <= DATA_WIDTH'($unsigned(r.addend));
    else if (cmd.mac_add) acc <= acc + prod;
    if (cmd.mac_mul) prod <= DATA_WIDTH'(rd_val * vsel);
  end

  always_comb begin
    sts.in_range = in_range;
    sts.op = r.operation;
    sts.at_end = (ptr == fill_cur);
    sts.col_ge = (rd_col >= col);
    sts.col_eq = (rd_col == col);
    sts.full = (fill_cur >= FW'(ROW_CAPACITY));
    sts.ptr_gt_pos = (ptr > pos);
  end

  // response built from controller decision
  always_comb begin
    rsp_next = '0;
    if (!in_range && r.operation <= smss_pkg::OP_MAC) rsp_next.status = smss_pkg::ST_RANGE;
    else begin
      case (r.operation)
        smss_pkg::OP_SET, smss_pkg::OP_GET, smss_pkg::OP_ALLOC: begin
          if (!sts.at_end && sts.col_eq) begin
            rsp_next.found = 1'b1;
            if (r.operation != smss_pkg::OP_SET)
              rsp_next.result_value = 32'(signed'(rd_val));
          end else if (r.operation != smss_pkg::OP_GET && sts.full)
            rsp_next.status = smss_pkg::ST_FULL;
        end
        smss_pkg::OP_MAC: rsp_next.result_value = 32'(signed'(acc));
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) rsp <= rsp_next;
  end
endmodule

/* hw/rtl/smss_ctrl.sv */
// Controller: sequences scan, insert shift, overwrite, vector load and row multiply.
module smss_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic           out_ready,
  output logic           out_valid,
  input  smss_pkg::sts_t sts,
  output smss_pkg::cmd_t cmd
);
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DEC   = 4'd1;
  localparam logic [3:0] S_RD    = 4'd2;
  localparam logic [3:0] S_CMP   = 4'd3;
  localparam logic [3:0] S_SHRD  = 4'd4;
  localparam logic [3:0] S_SHWR  = 4'd5;
  localparam logic [3:0] S_MRD   = 4'd6;
  localparam logic [3:0] S_MMUL  = 4'd7;
  localparam logic [3:0] S_MADD  = 4'd8;
  localparam logic [3:0] S_RESP  = 4'd9;
  localparam logic [3:0] S_OUT   = 4'd10;
  localparam logic [3:0] S_INS   = 4'd11;
  localparam logic [3:0] S_MVEC  = 4'd12;

  logic [3:0] state, state_next;

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_OUT);

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  always_comb begin
    cmd = '0;
    state_next = state;
    case (state)
      S_IDLE: if (in_valid) begin
        cmd.load_req = 1'b1;
        state_next = S_DEC;
      end
      S_DEC: begin
        cmd.ptr_clr = 1'b1;
        cmd.clr_acc = 1'b1;
        if (!sts.in_range || sts.op > smss_pkg::OP_MAC) state_next = S_RESP;
        else if (sts.op == smss_pkg::OP_LOAD) begin
          cmd.vec_wr = 1'b1;
          state_next = S_RESP;
        end else if (sts.op == smss_pkg::OP_MAC) state_next = S_MRD;
        else state_next = S_RD;
      end
      // scan: entry[ptr] readable next cycle
      S_RD: state_next = sts.at_end ? S_CMP : S_CMP;
      S_CMP: begin
        if (!sts.at_end && !sts.col_ge) begin
          cmd.ptr_inc = 1'b1;
          state_next = S_RD;
        end else if (!sts.at_end && sts.col_eq) begin
          cmd.wr_over = (sts.op == smss_pkg::OP_SET);
          cmd.out_load = 1'b1;
          state_next = S_OUT;
        end else begin
          cmd.out_load = 1'b1;
          if (sts.op == smss_pkg::OP_GET || sts.full) state_next = S_OUT;
          else begin
            cmd.ptr_to_fill = 1'b1; // pos <= ptr, ptr <= fill
            state_next = S_SHRD;
          end
        end
      end
      S_SHRD: begin
        cmd.rd_prev = 1'b1;
        state_next = sts.ptr_gt_pos ? S_SHWR : S_INS;
      end
      S_SHWR: begin
        cmd.wr_shift = 1'b1;
        cmd.ptr_dec = 1'b1;
        state_next = S_SHRD;
      end
      S_INS: begin
        cmd.wr_new = 1'b1;
        cmd.fill_inc = 1'b1;
        state_next = S_OUT;
      end
      S_MRD: state_next = sts.at_end ? S_RESP : S_MVEC;
      // entry valid; vector element of its column read here
      S_MVEC: state_next = S_MMUL;
      S_MMUL: begin
        cmd.mac_mul = 1'b1;
        cmd.ptr_inc = 1'b1;
        state_next = S_MADD;
      end
      S_MADD: begin
        cmd.mac_add = 1'b1;
        state_next = sts.at_end ? S_RESP : S_MVEC;
      end
      S_RESP: begin
        cmd.out_load = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: if (out_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end
endmodule

/* hw/rtl/sparse_matrix_store_spmv_top.sv */
// Top level of the sparse matrix store with row multiply-accumulate.
// One request at a time. Get and set walk the sorted row list, reading and
// then comparing each entry passed; an insert then shifts the tail, reading
// and then writing each moved entry; a row multiply reads each entry, then
// its vector element, then multiplies and accumulates. A vector load or an
// index out of range goes straight to the response, and the response waits
// on out_ready; all of it is bound by the one read port of the entry
// memory.
module sparse_matrix_store_spmv_top #(
  parameter int ROWS         = 64,
  parameter int COLS         = 64,
  parameter int ROW_CAPACITY = 16,
  parameter int DATA_WIDTH   = 32
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  smss_pkg::req_t in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output smss_pkg::rsp_t out_data,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic [0:0]     cfg_index,
  input  logic [6:0]     cfg_data
);
  logic [6:0] active_rows, active_cols;
  smss_pkg::cmd_t cmd;
  smss_pkg::sts_t sts;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_rows <= 7'd64;
      active_cols <= 7'd64;
    end else if (cfg_valid) begin
      if (cfg_index == smss_pkg::CFG_ROWS) active_rows <= cfg_data;
      else active_cols <= cfg_data;
    end
  end

  smss_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .out_ready(out_ready), .out_valid(out_valid), .sts(sts), .cmd(cmd)
  );

  smss_datapath #(.ROWS(ROWS), .COLS(COLS), .ROW_CAPACITY(ROW_CAPACITY),
                  .DATA_WIDTH(DATA_WIDTH)) u_dp (
    .clk(clk), .rst(rst), .req(in_data), .active_rows(active_rows),
    .active_cols(active_cols), .cmd(cmd), .sts(sts), .rsp(out_data)
  );
endmodule
